FILE: hw/rtl/canidt_pkg.sv
// shared types, constants and codes for the can identifier table
// no dependencies

package canidt_pkg;

    localparam int MAX_ENTRIES = 80;
    localparam int ADDR_W      = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    localparam int ID_W      = 29;
    localparam int LEN_W     = 4;
    localparam int PAYLOAD_W = 64;
    localparam int HITS_W    = 32;
    localparam int TOTAL_W   = 32;
    localparam int FILL_W    = 7;
    localparam int INDEX_W   = 8;
    localparam int OP_W      = 2;

    // classic frames carry at most eight bytes
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(8);

    localparam logic [OP_W-1:0] OP_RECEIVE = 2'd0;
    localparam logic [OP_W-1:0] OP_READ    = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

    typedef logic [1:0] out_sel_t;
    localparam out_sel_t SEL_NONE    = 2'd0;
    localparam out_sel_t SEL_STORED  = 2'd1;
    localparam out_sel_t SEL_UPDATED = 2'd2;
    localparam out_sel_t SEL_NEW     = 2'd3;

    typedef struct packed {
        logic [ID_W-1:0]      id;
        logic                 rtr;
        logic                 ext;
        logic [LEN_W-1:0]     len;
        logic [PAYLOAD_W-1:0] payload;
        logic [HITS_W-1:0]    hits;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // controller to datapath
    typedef struct packed {
        logic     load;
        logic     scan_inc;
        logic     wr_hit;
        logic     wr_new;
        logic     out_load;
        out_sel_t out_sel;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_end;
        logic hit;
        logic full;
        logic rd_ok;
    } dp_stat_t;

endpackage

FILE: hw/rtl/canidt_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies

module canidt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/canidt_dp.sv
// datapath: beat registers, table ram, scan index, counters and result registers
// depends on canidt_pkg and canidt_ram

module canidt_dp
    import canidt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  dp_cmd_t              cmd,
    output dp_stat_t             stat,
    input  logic [OP_W-1:0]      operation,
    input  logic [ID_W-1:0]      frame_id,
    input  logic                 frame_ext,
    input  logic                 frame_rtr,
    input  logic [LEN_W-1:0]     frame_len,
    input  logic [PAYLOAD_W-1:0] frame_payload,
    input  logic [INDEX_W-1:0]   read_index,
    output logic                 entry_valid,
    output logic [ID_W-1:0]      entry_id,
    output logic                 entry_ext,
    output logic                 entry_rtr,
    output logic [LEN_W-1:0]     entry_len,
    output logic [PAYLOAD_W-1:0] entry_payload,
    output logic [HITS_W-1:0]    entry_hits,
    output logic [FILL_W-1:0]    fill_level,
    output logic [TOTAL_W-1:0]   total_frames
);

    // latched beat
    logic [ID_W-1:0]      id_reg;
    logic                 ext_reg;
    logic                 rtr_reg;
    logic [LEN_W-1:0]     len_reg;
    logic [PAYLOAD_W-1:0] payload_reg;
    logic [INDEX_W-1:0]   rindex_reg;

    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   used_reg, used_next;
    logic [TOTAL_W-1:0] total_reg, total_next;

    logic                 out_valid_reg;
    entry_t               out_entry_reg;
    logic [FILL_W-1:0]    out_fill_reg;
    logic [TOTAL_W-1:0]   out_total_reg;

    entry_t rdata;
    entry_t upd_entry;
    entry_t new_entry;
    entry_t sel_entry;
    logic   sel_valid;
    logic   ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    entry_t            ram_wdata;

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.load)
        begin
            idx_next = (operation == OP_READ) ? CNT_W'(read_index[ADDR_W-1:0]) : '0;
        end
        else if (cmd.scan_inc)
        begin
            idx_next = idx_reg + CNT_W'(1);
        end
    end

    always_comb
    begin
        used_next  = used_reg;
        total_next = total_reg;
        if (cmd.load && operation == OP_CLEAR)
        begin
            used_next  = '0;
            total_next = '0;
        end
        else if (cmd.load && operation == OP_RECEIVE)
        begin
            total_next = total_reg + TOTAL_W'(1);
        end
        else if (cmd.wr_new)
        begin
            used_next = used_reg + CNT_W'(1);
        end
    end

    always_comb
    begin
        upd_entry         = rdata;
        upd_entry.len     = len_reg;
        upd_entry.payload = payload_reg;
        upd_entry.hits    = rdata.hits + HITS_W'(1);

        new_entry.id      = id_reg;
        new_entry.ext     = ext_reg;
        new_entry.rtr     = rtr_reg;
        new_entry.len     = len_reg;
        new_entry.payload = payload_reg;
        new_entry.hits    = HITS_W'(1);
    end

    assign ram_we    = cmd.wr_hit | cmd.wr_new;
    assign ram_waddr = cmd.wr_new ? used_reg[ADDR_W-1:0] : idx_reg[ADDR_W-1:0];
    assign ram_wdata = cmd.wr_new ? new_entry : upd_entry;

    canidt_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(MAX_ENTRIES)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(idx_next[ADDR_W-1:0]),
        .rdata(rdata)
    );

    always_comb
    begin
        sel_valid = 1'b1;
        sel_entry = '0;
        case (cmd.out_sel)
            SEL_STORED:  sel_entry = rdata;
            SEL_UPDATED: sel_entry = upd_entry;
            SEL_NEW:     sel_entry = new_entry;
            default:     sel_valid = 1'b0;
        endcase
    end

    assign stat.scan_end = (idx_reg >= used_reg);
    assign stat.hit      = (rdata.id == id_reg);
    assign stat.full     = (used_reg >= CNT_W'(MAX_ENTRIES));
    assign stat.rd_ok    = ((INDEX_W + 1)'(rindex_reg) < (INDEX_W + 1)'(used_reg));

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            id_reg      <= frame_id;
            ext_reg     <= frame_ext;
            rtr_reg     <= frame_rtr;
            len_reg     <= (frame_len > LEN_MAX) ? LEN_MAX : frame_len;
            payload_reg <= frame_payload;
            rindex_reg  <= read_index;
        end
        if (cmd.out_load)
        begin
            out_entry_reg <= sel_entry;
            out_fill_reg  <= FILL_W'(used_next);
            out_total_reg <= total_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            used_reg      <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            used_reg  <= used_next;
            total_reg <= total_next;
            if (cmd.out_load)
            begin
                out_valid_reg <= sel_valid;
            end
        end
    end

    assign entry_valid   = out_valid_reg;
    assign entry_id      = out_entry_reg.id;
    assign entry_ext     = out_entry_reg.ext;
    assign entry_rtr     = out_entry_reg.rtr;
    assign entry_len     = out_entry_reg.len;
    assign entry_payload = out_entry_reg.payload;
    assign entry_hits    = out_entry_reg.hits;
    assign fill_level    = out_fill_reg;
    assign total_frames  = out_total_reg;

endmodule

FILE: hw/rtl/canidt_ctrl.sv
// controller: sequences accept, table scan, write-back and the result strobe
// depends on canidt_pkg

module canidt_ctrl
    import canidt_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [OP_W-1:0] operation,
    output logic            busy,
    output logic            done,
    output dp_cmd_t         cmd,
    input  dp_stat_t        stat
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_READ = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       done_reg, done_next;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cmd        = '0;
        cmd.out_sel = SEL_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (operation == OP_RECEIVE)
                    begin
                        state_next = ST_SCAN;
                    end
                    else if (operation == OP_READ)
                    begin
                        state_next = ST_READ;
                    end
                    else
                    begin
                        // clear and the unused code answer at once
                        cmd.out_load = 1'b1;
                        done_next    = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                if (stat.scan_end)
                begin
                    cmd.out_load = 1'b1;
                    done_next    = 1'b1;
                    state_next   = ST_IDLE;
                    if (!stat.full)
                    begin
                        cmd.wr_new  = 1'b1;
                        cmd.out_sel = SEL_NEW;
                    end
                end
                else if (stat.hit)
                begin
                    cmd.wr_hit   = 1'b1;
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = SEL_UPDATED;
                    done_next    = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    cmd.scan_inc = 1'b1;
                end
            end
            ST_READ:
            begin
                cmd.out_load = 1'b1;
                cmd.out_sel  = stat.rd_ok ? SEL_STORED : SEL_NONE;
                done_next    = 1'b1;
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

endmodule

FILE: hw/rtl/can_id_last_frame_table_top.sv
// top level of the can identifier table: last frame and hit count per identifier
// depends on canidt_pkg, canidt_ctrl and canidt_dp (which holds canidt_ram)

// A beat is taken on a rising edge with start high and busy low, and each beat
// gives exactly one result, shown for a single cycle with done high; the
// receiver cannot stall, so capture it then. Clear and the unused operation
// code show their result in the cycle right after the start edge. A read
// passes through the registered table read and then the read state. A receive
// walks the table one entry a cycle through the single read port of the table
// ram and stops at the matching identifier, or at the fill level when there is
// none (the table holds at most 80 entries). busy drops in the cycle the
// result appears, so a new beat may start then. There is no clearing pass
// after reset: the fill level alone marks which entries are live, and the
// clear operation only zeroes the counters.

module can_id_last_frame_table_top
    import canidt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [OP_W-1:0]      operation,
    input  logic [ID_W-1:0]      frame_id,
    input  logic                 frame_ext,
    input  logic                 frame_rtr,
    input  logic [LEN_W-1:0]     frame_len,
    input  logic [PAYLOAD_W-1:0] frame_payload,
    input  logic [INDEX_W-1:0]   read_index,
    output logic                 done,
    output logic                 entry_valid,
    output logic [ID_W-1:0]      entry_id,
    output logic                 entry_ext,
    output logic                 entry_rtr,
    output logic [LEN_W-1:0]     entry_len,
    output logic [PAYLOAD_W-1:0] entry_payload,
    output logic [HITS_W-1:0]    entry_hits,
    output logic [FILL_W-1:0]    fill_level,
    output logic [TOTAL_W-1:0]   total_frames
);

    // command and status between the controller and the datapath
    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencer: idle, scan over the table, or single read
    canidt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .operation(operation),
        .busy     (busy),
        .done     (done),
        .cmd      (cmd),
        .stat     (stat)
    );

    // table storage, identifier compare, counters and result registers
    canidt_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .operation    (operation),
        .frame_id     (frame_id),
        .frame_ext    (frame_ext),
        .frame_rtr    (frame_rtr),
        .frame_len    (frame_len),
        .frame_payload(frame_payload),
        .read_index   (read_index),
        .entry_valid  (entry_valid),
        .entry_id     (entry_id),
        .entry_ext    (entry_ext),
        .entry_rtr    (entry_rtr),
        .entry_len    (entry_len),
        .entry_payload(entry_payload),
        .entry_hits   (entry_hits),
        .fill_level   (fill_level),
        .total_frames (total_frames)
    );

endmodule
